// ===== src/rvsd_pkg.sv =====
// ----------------------------------------------------------------------------
// rvsd_pkg
// opcode, funct3, alu class and alu control codes shared by the decode/execute
// core
// ----------------------------------------------------------------------------
package rvsd_pkg;

    // supported major opcodes
    localparam logic [6:0] OPC_R     = 7'b0110011;
    localparam logic [6:0] OPC_I     = 7'b0010011;
    localparam logic [6:0] OPC_LUI   = 7'b0110111;
    localparam logic [6:0] OPC_LOAD  = 7'b0000011;
    localparam logic [6:0] OPC_STORE = 7'b0100011;
    localparam logic [6:0] OPC_JAL   = 7'b1101111;
    localparam logic [6:0] OPC_BEQ   = 7'b1100011;
    localparam logic [6:0] OPC_NONE  = 7'b0000000;

    // funct3 codes of the arithmetic class
    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_XOR = 3'd4;
    localparam logic [2:0] F3_SRA = 3'd5;
    localparam logic [2:0] F3_OR  = 3'd6;

    typedef enum logic [1:0] {
        CLS_ADDR  = 2'd0,
        CLS_BRNCH = 2'd1,
        CLS_ARITH = 2'd2,
        CLS_JUMP  = 2'd3
    } t_alu_class;

    typedef enum logic [3:0] {
        CTL_AND  = 4'd0,
        CTL_OR   = 4'd1,
        CTL_ADD  = 4'd2,
        CTL_XOR  = 4'd3,
        CTL_SRA  = 4'd4,
        CTL_SUB  = 4'd6,
        CTL_PASS = 4'd8,
        CTL_JUMP = 4'd15
    } t_alu_ctl;

    // main control flags
    typedef struct packed {
        logic reg_write;
        logic alu_src;
        logic branch;
        logic mem_read;
        logic mem_write;
        logic mem_to_reg;
    } t_ctrl;

endpackage

// ===== src/rv32i_subset_decode_execute_core.sv =====
// ----------------------------------------------------------------------------
// rv32i_subset_decode_execute_core
// Decodes one instruction word from an RV32I subset (R, I arithmetic, LUI,
// load, store, JAL, BEQ) and executes it in the same pass. Each word brings
// the instruction and the two source register values; the result word
// carries the control flags, alu class, alu control, sign-extended immediate,
// alu result and the echoed opcode (0 when unsupported). The second alu
// operand is the immediate when alu_src is set and rs2 otherwise. The core
// takes one word per clock while the result side drains: a word is captured
// in an input register, decoded and executed by one short combinational
// pass (a 32-bit add/subtract, logic operation or barrel shift plus
// selection) and lands in the result register, which raises o_out_valid.
// Stalls on the output side back up through the two registers; the input
// stalls only when both hold a word and the result is not being taken.
// ----------------------------------------------------------------------------
module rv32i_subset_decode_execute_core
    import rvsd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    // input word channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic        [31:0] i_instruction_word,
    input  logic signed [31:0] i_rs1_value,
    input  logic signed [31:0] i_rs2_value,

    // result word channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_reg_write,
    output logic               o_alu_src,
    output logic               o_branch,
    output logic               o_mem_read,
    output logic               o_mem_write,
    output logic               o_mem_to_reg,
    output logic        [1:0]  o_alu_class,
    output logic        [3:0]  o_alu_control,
    output logic signed [31:0] o_immediate,
    output logic signed [31:0] o_exec_result,
    output logic        [6:0]  o_decoded_opcode
);

    // input register
    logic        r_in_valid;
    logic [31:0] r_instr;
    logic [31:0] r_rs1;
    logic [31:0] r_rs2;

    // result register
    logic        r_out_valid;
    t_ctrl       r_ctrl;
    t_alu_class  r_cls;
    t_alu_ctl    r_ctl;
    logic [31:0] r_imm;
    logic [31:0] r_res;
    logic [6:0]  r_opc;

    // pipeline advance
    logic out_free;
    logic in_move;

    // decode/execute pass
    logic [6:0]  opc;
    logic [2:0]  f3;
    t_ctrl       n_ctrl;
    t_alu_class  n_cls;
    t_alu_ctl    n_ctl;
    logic [31:0] n_imm;
    logic [31:0] n_res;
    logic [6:0]  n_opc;
    logic [31:0] opnd_b;

    // result register can take a new word when empty or being drained
    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_move    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    // capture payload whenever the input register is free
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_instr <= i_instruction_word;
            r_rs1   <= i_rs1_value;
            r_rs2   <= i_rs2_value;
        end
    end

    assign opc = r_instr[6:0];
    assign f3  = r_instr[14:12];

    // main decoder: flags, class and opcode echo
    always_comb begin
        n_ctrl = '0;
        n_cls  = CLS_ADDR;
        n_opc  = opc;
        unique case (opc)
            OPC_R: begin
                n_ctrl.reg_write = 1'b1;
                n_cls            = CLS_ARITH;
            end
            OPC_I, OPC_LUI: begin
                n_ctrl.reg_write = 1'b1;
                n_ctrl.alu_src   = 1'b1;
                n_cls            = CLS_ARITH;
            end
            OPC_LOAD: begin
                n_ctrl.reg_write  = 1'b1;
                n_ctrl.alu_src    = 1'b1;
                n_ctrl.mem_read   = 1'b1;
                n_ctrl.mem_to_reg = 1'b1;
            end
            OPC_STORE: begin
                n_ctrl.alu_src   = 1'b1;
                n_ctrl.mem_write = 1'b1;
            end
            OPC_JAL: begin
                n_ctrl.reg_write = 1'b1;
                n_ctrl.branch    = 1'b1;
                n_cls            = CLS_JUMP;
            end
            OPC_BEQ: begin
                n_ctrl.branch = 1'b1;
                n_cls         = CLS_BRNCH;
            end
            default: begin
                n_opc = OPC_NONE;
            end
        endcase
    end

    // alu control from class and funct3; lui always passes the operand
    always_comb begin
        unique case (n_cls)
            CLS_ARITH: begin
                if (opc == OPC_LUI) begin
                    n_ctl = CTL_PASS;
                end else begin
                    unique case (f3)
                        F3_XOR:  n_ctl = CTL_XOR;
                        F3_OR:   n_ctl = CTL_OR;
                        F3_SRA:  n_ctl = CTL_SRA;
                        default: n_ctl = CTL_ADD;
                    endcase
                end
            end
            CLS_BRNCH: n_ctl = CTL_SUB;
            CLS_JUMP:  n_ctl = CTL_JUMP;
            default:   n_ctl = CTL_ADD;
        endcase
    end

    // immediate per format
    always_comb begin
        unique case (opc)
            OPC_I: begin
                case (f3) inside
                    F3_ADD, F3_XOR, F3_OR: n_imm = {{20{r_instr[31]}}, r_instr[31:20]};
                    F3_SRA:                n_imm = {27'd0, r_instr[24:20]};
                    default:               n_imm = '0;
                endcase
            end
            OPC_LUI:   n_imm = {r_instr[31:12], 12'd0};
            OPC_LOAD:  n_imm = {{20{r_instr[31]}}, r_instr[31:20]};
            OPC_STORE: n_imm = {{20{r_instr[31]}}, r_instr[31:25], r_instr[11:7]};
            OPC_BEQ:   n_imm = {{19{r_instr[31]}}, r_instr[31], r_instr[7],
                                r_instr[30:25], r_instr[11:8], 1'b0};
            OPC_JAL:   n_imm = {{11{r_instr[31]}}, r_instr[31], r_instr[19:12],
                                r_instr[20], r_instr[30:21], 1'b0};
            default:   n_imm = '0;
        endcase
    end

    // alu; shifts use the low five bits of the second operand
    assign opnd_b = n_ctrl.alu_src ? n_imm : r_rs2;

    always_comb begin
        unique case (n_ctl)
            CTL_ADD:  n_res = r_rs1 + opnd_b;
            CTL_SUB:  n_res = r_rs1 - opnd_b;
            CTL_AND:  n_res = r_rs1 & opnd_b;
            CTL_OR:   n_res = r_rs1 | opnd_b;
            CTL_XOR:  n_res = r_rs1 ^ opnd_b;
            CTL_SRA:  n_res = $unsigned($signed(r_rs1) >>> opnd_b[4:0]);
            CTL_PASS: n_res = opnd_b;
            default:  n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_move) begin
            r_ctrl <= n_ctrl;
            r_cls  <= n_cls;
            r_ctl  <= n_ctl;
            r_imm  <= n_imm;
            r_res  <= n_res;
            r_opc  <= n_opc;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_reg_write      = r_ctrl.reg_write;
    assign o_alu_src        = r_ctrl.alu_src;
    assign o_branch         = r_ctrl.branch;
    assign o_mem_read       = r_ctrl.mem_read;
    assign o_mem_write      = r_ctrl.mem_write;
    assign o_mem_to_reg     = r_ctrl.mem_to_reg;
    assign o_alu_class      = r_cls;
    assign o_alu_control    = r_ctl;
    assign o_immediate      = r_imm;
    assign o_exec_result    = r_res;
    assign o_decoded_opcode = r_opc;

    // input only backs up while a word sits in the input register
    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with empty input register");

    // a word in the input register reaches the result register once it is free
    a_word_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_free) |=> r_out_valid)
        else $error("word lost between input and result register");

    // unsupported opcode raises no control flag
    a_unknown_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_opc == OPC_NONE) |-> (r_ctrl == '0))
        else $error("flags set for unsupported opcode");

    // loads write back from memory through the address adder
    a_load_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ctrl.mem_read) |->
            (r_ctrl.reg_write && r_ctrl.mem_to_reg && r_cls == CLS_ADDR))
        else $error("inconsistent load control");

    // branch flag only with branch or jump class
    a_branch_cls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ctrl.branch) |-> (r_cls == CLS_BRNCH || r_cls == CLS_JUMP))
        else $error("branch flag with wrong alu class");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rv32i subset decode/execute core. Instruction
// words with source operands go in through a valid/stall channel; each word
// is predicted on acceptance and the result word is compared field by field.
// Both channels idle and stall at random, with a full-rate stretch and a few
// pauses that let the core drain completely.
// ----------------------------------------------------------------------------
module tb_top;
    import rvsd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_WORDS = 480;
    localparam int FULL_RATE_WORDS = 120;

    localparam logic [6:0] SUPPORTED_OPCS [7] = '{
        OPC_R, OPC_I, OPC_LUI, OPC_LOAD, OPC_STORE, OPC_JAL, OPC_BEQ
    };

    // one predicted result word
    typedef struct packed {
        t_ctrl       ctrl;
        t_alu_class  cls;
        t_alu_ctl    ctl;
        logic [31:0] imm;
        logic [31:0] res;
        logic [6:0]  opc;
    } t_exec_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic        [31:0] instr_word = '0;
    logic signed [31:0] rs1_value = '0;
    logic signed [31:0] rs2_value = '0;
    logic               out_stall = 1'b0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic               o_reg_write;
    logic               o_alu_src;
    logic               o_branch;
    logic               o_mem_read;
    logic               o_mem_write;
    logic               o_mem_to_reg;
    logic        [1:0]  o_alu_class;
    logic        [3:0]  o_alu_control;
    logic signed [31:0] o_immediate;
    logic signed [31:0] o_exec_result;
    logic        [6:0]  o_decoded_opcode;

    // results still owed by the core, oldest first
    t_exec_word pending_results [$];

    int  mismatches = 0;
    int  words_sent = 0;
    int  results_checked = 0;
    int  cycle_count = 0;
    int  stall_hold = 0;
    // when set, neither side idles: full-rate stretch
    bit  calm = 1'b0;

    rv32i_subset_decode_execute_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_instruction_word(instr_word),
        .i_rs1_value      (rs1_value),
        .i_rs2_value      (rs2_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_reg_write      (o_reg_write),
        .o_alu_src        (o_alu_src),
        .o_branch         (o_branch),
        .o_mem_read       (o_mem_read),
        .o_mem_write      (o_mem_write),
        .o_mem_to_reg     (o_mem_to_reg),
        .o_alu_class      (o_alu_class),
        .o_alu_control    (o_alu_control),
        .o_immediate      (o_immediate),
        .o_exec_result    (o_exec_result),
        .o_decoded_opcode (o_decoded_opcode)
    );

    // 4 time unit clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // output stall: random on/off runs, released during the full-rate stretch
    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            out_stall <= 1'b0;
            stall_hold <= 0;
        end else if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < 35);
            stall_hold <= pick_gap();
        end
    end

    // decode and execute one instruction word
    function automatic t_exec_word predict_exec(input logic [31:0] w,
                                                input logic [31:0] a,
                                                input logic [31:0] b);
        t_exec_word e;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [31:0] op2;
        opc = w[6:0];
        f3  = w[14:12];
        e = '0;
        e.cls = CLS_ADDR;
        e.ctl = CTL_ADD;
        e.opc = opc;

        // main control flags and alu class
        case (opc)
            OPC_R: begin
                e.ctrl.reg_write = 1'b1;
                e.cls = CLS_ARITH;
            end
            OPC_I, OPC_LUI: begin
                e.ctrl.reg_write = 1'b1;
                e.ctrl.alu_src = 1'b1;
                e.cls = CLS_ARITH;
            end
            OPC_LOAD: begin
                e.ctrl.reg_write = 1'b1;
                e.ctrl.alu_src = 1'b1;
                e.ctrl.mem_read = 1'b1;
                e.ctrl.mem_to_reg = 1'b1;
            end
            OPC_STORE: begin
                e.ctrl.alu_src = 1'b1;
                e.ctrl.mem_write = 1'b1;
            end
            OPC_JAL: begin
                e.ctrl.reg_write = 1'b1;
                e.ctrl.branch = 1'b1;
                e.cls = CLS_JUMP;
            end
            OPC_BEQ: begin
                e.ctrl.branch = 1'b1;
                e.cls = CLS_BRNCH;
            end
            default: e.opc = OPC_NONE;
        endcase

        // alu control; lui passes regardless of its funct3 bits
        case (e.cls)
            CLS_ARITH: begin
                if (opc == OPC_LUI) e.ctl = CTL_PASS;
                else begin
                    case (f3)
                        F3_XOR:  e.ctl = CTL_XOR;
                        F3_OR:   e.ctl = CTL_OR;
                        F3_SRA:  e.ctl = CTL_SRA;
                        default: e.ctl = CTL_ADD;
                    endcase
                end
            end
            CLS_BRNCH: e.ctl = CTL_SUB;
            CLS_JUMP:  e.ctl = CTL_JUMP;
            default:   e.ctl = CTL_ADD;
        endcase

        // immediate by format
        case (opc)
            OPC_I: begin
                case (f3)
                    F3_ADD, F3_XOR, F3_OR: e.imm = {{20{w[31]}}, w[31:20]};
                    F3_SRA:                e.imm = {27'd0, w[24:20]};
                    default:               e.imm = '0;
                endcase
            end
            OPC_LUI:   e.imm = {w[31:12], 12'd0};
            OPC_LOAD:  e.imm = {{20{w[31]}}, w[31:20]};
            OPC_STORE: e.imm = {{20{w[31]}}, w[31:25], w[11:7]};
            OPC_BEQ:   e.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            OPC_JAL:   e.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            default:   e.imm = '0;
        endcase

        op2 = e.ctrl.alu_src ? e.imm : b;
        case (e.ctl)
            CTL_ADD:  e.res = a + op2;
            CTL_SUB:  e.res = a - op2;
            CTL_AND:  e.res = a & op2;
            CTL_OR:   e.res = a | op2;
            CTL_XOR:  e.res = a ^ op2;
            CTL_SRA:  e.res = $signed(a) >>> op2[4:0];
            CTL_PASS: e.res = op2;
            default:  e.res = '0;
        endcase
        return e;
    endfunction

    // offer one word, hold it through stalls, predict on acceptance
    task automatic send_word(input logic [31:0] w, input logic [31:0] a,
                             input logic [31:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid   <= 1'b1;
        instr_word <= w;
        rs1_value  <= a;
        rs2_value  <= b;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(predict_exec(w, a, b));
        words_sent++;
    endtask

    // stop sending until every owed result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // compare each accepted result word with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_exec_word want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing outstanding");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                check_field("reg_write", 32'(want.ctrl.reg_write), 32'(o_reg_write));
                check_field("alu_src", 32'(want.ctrl.alu_src), 32'(o_alu_src));
                check_field("branch", 32'(want.ctrl.branch), 32'(o_branch));
                check_field("mem_read", 32'(want.ctrl.mem_read), 32'(o_mem_read));
                check_field("mem_write", 32'(want.ctrl.mem_write), 32'(o_mem_write));
                check_field("mem_to_reg", 32'(want.ctrl.mem_to_reg), 32'(o_mem_to_reg));
                check_field("alu_class", 32'(want.cls), 32'(o_alu_class));
                check_field("alu_control", 32'(want.ctl), 32'(o_alu_control));
                check_field("immediate", want.imm, o_immediate);
                check_field("exec_result", want.res, o_exec_result);
                check_field("decoded_opcode", 32'(want.opc), 32'(o_decoded_opcode));
            end
        end
    end

    // operand: mostly random, sometimes a corner value
    function automatic logic [31:0] pick_operand();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)  return 32'h0000_0000;
        if (r < 8)  return 32'h7FFF_FFFF;
        if (r < 12) return 32'h8000_0000;
        if (r < 16) return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    // instruction: mostly a supported opcode with random fields, rest noise
    function automatic logic [31:0] pick_instruction();
        logic [31:0] w;
        int r;
        w = $urandom();
        r = $urandom_range(0, 99);
        if (r < 88) w[6:0] = SUPPORTED_OPCS[$urandom_range(0, 6)];
        else if (r < 94) w[1:0] = 2'b11;
        return w;
    endfunction

    // one of each opcode, including lui with funct3 bits set and an unknown one
    task automatic test_opcode_table();
        send_word({7'h00, 5'd2, 5'd1, F3_ADD, 5'd3, OPC_R}, 32'd5, 32'd7);
        send_word({12'hFFF, 5'd1, F3_ADD, 5'd3, OPC_I}, 32'd10, 32'hDEAD_BEEF);
        send_word({20'h8000D, 5'd3, OPC_LUI}, 32'h1234_5678, 32'hFFFF_FFFF);
        send_word({12'h800, 5'd2, 3'd2, 5'd4, OPC_LOAD}, 32'h0000_1000, 32'd0);
        send_word({7'h40, 5'd9, 5'd2, 3'd2, 5'h00, OPC_STORE}, 32'h10, 32'd3);
        send_word({25'h1FF_FFFF, OPC_JAL}, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word({25'h1FF_FFFF, OPC_BEQ}, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word({25'h1FF_FFFF, 7'h7F}, 32'h7FFF_FFFF, 32'd1);
    endtask

    // every funct3 on r-type, funct7 set, shift amount wider than 5 bits
    task automatic test_funct3_decode();
        for (int f = 0; f < 8; f++) begin
            send_word({7'h20, 5'd2, 5'd1, f[2:0], 5'd3, OPC_R},
                      32'h8000_0001, 32'h0000_0021);
        end
    endtask

    // i-type, store and branch immediate forms, wrap-around and extreme offsets
    task automatic test_immediate_forms();
        send_word({12'hFFF, 5'd1, 3'd1, 5'd3, OPC_I}, 32'd9, 32'd4);
        send_word({12'hABC, 5'd1, 3'd7, 5'd3, OPC_I}, 32'd9, 32'd4);
        send_word({7'h7F, 5'd31, 5'd1, F3_SRA, 5'd3, OPC_I}, 32'h8000_0000, 32'd0);
        send_word({12'h7FF, 5'd1, F3_ADD, 5'd3, OPC_I}, 32'h7FFF_FFFF, 32'd0);
        send_word({7'h3F, 5'd9, 5'd2, 3'd2, 5'h1F, OPC_STORE}, 32'hFFFF_FFFF, 32'd0);
        send_word({7'h00, 5'd2, 5'd1, 3'd0, 5'h00, OPC_BEQ}, 32'h8000_0000, 32'h8000_0000);
    endtask

    // random words with random gaps, draining now and then
    task automatic test_random_stream(input int count);
        for (int n = 0; n < count; n++) begin
            send_word(pick_instruction(), pick_operand(), pick_operand());
            if (n % 160 == 159) drain_results();
        end
    endtask

    // no idling on either side, one word per clock
    task automatic test_back_to_back(input int count);
        calm = 1'b1;
        for (int n = 0; n < count; n++) begin
            send_word(pick_instruction(), pick_operand(), pick_operand());
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_opcode_table();
        test_funct3_decode();
        test_immediate_forms();
        drain_results();
        test_random_stream(RANDOM_WORDS);
        test_back_to_back(FULL_RATE_WORDS);
        drain_results();
        repeat (8) @(posedge i_clk);

        $display("summary: %0d words decoded, %0d results compared, %0d mismatches",
                 words_sent, results_checked, mismatches);
        $display("summary: all opcodes and funct3 codes, random gaps and stalls, full rate");
        if (mismatches == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// ===== rv32i_subset_decode_execute_core.f =====
src/rvsd_pkg.sv
src/rv32i_subset_decode_execute_core.sv
test/tb_top.sv
